@@ rtl/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg: shared constants for the segment intersection block
// Default coordinate width and the depth of the front end, which the top level
// needs in order to lay out its stage enables.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // Width of one signed fixed-point coordinate.
  localparam int COORD_BITS = 16;

  // Register stages in the cross-product front end.
  localparam int FRONT_STAGES = 5;

endpackage

@@ rtl/ssi_front.sv @@
// ----------------------------------------------------------------------------
// ssi_front: cross products, range test and numerators
// Five register stages. These are the edge differences, the six products, the
// three cross products, the signs and magnitudes, and then the hit decision
// with the two numerator products.
// ----------------------------------------------------------------------------
module ssi_front #(
  parameter int COORD_BITS = ssi_pkg::COORD_BITS
) (
  input  logic                                   clk,
  input  logic [ssi_pkg::FRONT_STAGES-1:0]       en,
  input  logic signed [COORD_BITS-1:0]           a1x,
  input  logic signed [COORD_BITS-1:0]           a1y,
  input  logic signed [COORD_BITS-1:0]           a2x,
  input  logic signed [COORD_BITS-1:0]           a2y,
  input  logic signed [COORD_BITS-1:0]           b1x,
  input  logic signed [COORD_BITS-1:0]           b1y,
  input  logic signed [COORD_BITS-1:0]           b2x,
  input  logic signed [COORD_BITS-1:0]           b2y,
  output logic                                   hit,
  output logic                                   neg_x,
  output logic                                   neg_y,
  output logic signed [COORD_BITS-1:0]           base_x,
  output logic signed [COORD_BITS-1:0]           base_y,
  output logic [3*COORD_BITS+1:0]                num_x,
  output logic [3*COORD_BITS+1:0]                num_y,
  output logic [2*COORD_BITS+1:0]                den
);

  localparam int DW = COORD_BITS + 1;   // edge difference
  localparam int PW = 2 * COORD_BITS + 2; // product
  localparam int CW = 2 * COORD_BITS + 3; // cross product
  localparam int MW = 2 * COORD_BITS + 2; // cross product magnitude

  // Stage 0: differences.
  logic signed [DW-1:0]         dax0, day0, dbx0, dby0, ox0, oy0;
  logic signed [COORD_BITS-1:0] a1x0, a1y0;
  // Stage 1: products.
  logic signed [PW-1:0]         pa1, pa2, pb1, pb2, pc1, pc2;
  logic signed [DW-1:0]         dax1, day1;
  logic signed [COORD_BITS-1:0] a1x1, a1y1;
  // Stage 2: cross products.
  logic signed [CW-1:0]         va2, vb2, vc2;
  logic signed [DW-1:0]         dax2, day2;
  logic signed [COORD_BITS-1:0] a1x2, a1y2;
  // Stage 3: signs and magnitudes.
  logic                         va_zero, vb_zero, vc_zero, sa_eq_sc, sb_eq_sc;
  logic [MW-1:0]                ma, mb, mc;
  logic [COORD_BITS-1:0]        mdx, mdy;
  logic                         negx3, negy3;
  logic signed [COORD_BITS-1:0] a1x3, a1y3;

  logic signed [CW-1:0]         va_neg, vb_neg, vc_neg;
  logic signed [DW-1:0]         dax_neg, day_neg;

  assign va_neg  = -va2;
  assign vb_neg  = -vb2;
  assign vc_neg  = -vc2;
  assign dax_neg = -dax2;
  assign day_neg = -day2;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dax0 <= DW'(a2x) - DW'(a1x);
      day0 <= DW'(a2y) - DW'(a1y);
      dbx0 <= DW'(b2x) - DW'(b1x);
      dby0 <= DW'(b2y) - DW'(b1y);
      ox0  <= DW'(a1x) - DW'(b1x);
      oy0  <= DW'(a1y) - DW'(b1y);
      a1x0 <= a1x;
      a1y0 <= a1y;
    end
    if (en[1]) begin
      pa1  <= dbx0 * oy0;
      pa2  <= dby0 * ox0;
      pb1  <= dax0 * oy0;
      pb2  <= day0 * ox0;
      pc1  <= dby0 * dax0;
      pc2  <= dbx0 * day0;
      dax1 <= dax0;
      day1 <= day0;
      a1x1 <= a1x0;
      a1y1 <= a1y0;
    end
    if (en[2]) begin
      va2  <= CW'(pa1) - CW'(pa2);
      vb2  <= CW'(pb1) - CW'(pb2);
      vc2  <= CW'(pc1) - CW'(pc2);
      dax2 <= dax1;
      day2 <= day1;
      a1x2 <= a1x1;
      a1y2 <= a1y1;
    end
    if (en[3]) begin
      va_zero  <= (va2 == '0);
      vb_zero  <= (vb2 == '0);
      vc_zero  <= (vc2 == '0);
      sa_eq_sc <= (va2[CW-1] == vc2[CW-1]);
      sb_eq_sc <= (vb2[CW-1] == vc2[CW-1]);
      ma       <= va2[CW-1] ? va_neg[MW-1:0] : va2[MW-1:0];
      mb       <= vb2[CW-1] ? vb_neg[MW-1:0] : vb2[MW-1:0];
      mc       <= vc2[CW-1] ? vc_neg[MW-1:0] : vc2[MW-1:0];
      mdx      <= dax2[DW-1] ? dax_neg[COORD_BITS-1:0] : dax2[COORD_BITS-1:0];
      mdy      <= day2[DW-1] ? day_neg[COORD_BITS-1:0] : day2[COORD_BITS-1:0];
      // The offset sign folds the sign of the ratio and of the edge direction.
      negx3    <= (va2[CW-1] != vc2[CW-1]) != dax2[DW-1];
      negy3    <= (va2[CW-1] != vc2[CW-1]) != day2[DW-1];
      a1x3     <= a1x2;
      a1y3     <= a1y2;
    end
    if (en[4]) begin
      // Both ratios must lie in the closed unit range: zero, or same sign as
      // the denominator and no larger in magnitude.
      hit    <= !vc_zero && (va_zero || (sa_eq_sc && ma <= mc))
                         && (vb_zero || (sb_eq_sc && mb <= mc));
      num_x  <= ma * mdx;
      num_y  <= ma * mdy;
      den    <= mc;
      neg_x  <= negx3;
      neg_y  <= negy3;
      base_x <= a1x3;
      base_y <= a1y3;
    end
  end

endmodule

@@ rtl/ssi_div.sv @@
// ----------------------------------------------------------------------------
// ssi_div: pipelined restoring divider
// One quotient bit per stage. A side word rides along with each item.
// ----------------------------------------------------------------------------
module ssi_div #(
  parameter int COORD_BITS = ssi_pkg::COORD_BITS,
  parameter int SIDE_W     = 1
) (
  input  logic                        clk,
  input  logic [COORD_BITS-1:0]       en,
  input  logic [3*COORD_BITS+1:0]     num,
  input  logic [2*COORD_BITS+1:0]     den,
  input  logic [SIDE_W-1:0]           side_in,
  output logic [COORD_BITS-1:0]       quot,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int QW = COORD_BITS;         // quotient bits, one per stage
  localparam int MW = 2 * COORD_BITS + 2; // divisor and remainder

  logic [MW-1:0]     rem_q  [QW];
  logic [QW-1:0]     lq_q   [QW];  // dividend bits still to shift in, quotient bits in
  logic [MW-1:0]     den_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW-1:0]     rem_prev, den_prev;
    logic [QW-1:0]     lq_prev;
    logic [SIDE_W-1:0] side_prev;
    logic [MW:0]       sh, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_prev  = num[3*COORD_BITS+1:QW];
      assign lq_prev   = num[QW-1:0];
      assign den_prev  = den;
      assign side_prev = side_in;
    end else begin : g_next
      assign rem_prev  = rem_q[k-1];
      assign lq_prev   = lq_q[k-1];
      assign den_prev  = den_q[k-1];
      assign side_prev = side_q[k-1];
    end

    assign sh   = {rem_prev, lq_prev[QW-1]};
    assign diff = sh - {1'b0, den_prev};
    assign ge   = (sh >= {1'b0, den_prev});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_q[k]  <= ge ? diff[MW-1:0] : sh[MW-1:0];
        lq_q[k]   <= {lq_prev[QW-2:0], ge};
        den_q[k]  <= den_prev;
        side_q[k] <= side_prev;
      end
    end
  end

  assign quot     = lq_q[QW-1];
  assign side_out = side_q[QW-1];

endmodule

@@ rtl/segment_segment_intersect.sv @@
// ----------------------------------------------------------------------------
// segment_segment_intersect: fixed-point segment/segment intersection
// Tests two segments for a crossing and gives the crossing point.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item holds the two end points of segment A and of
//   segment B. Output stream m_*: one item per input item; m_tuser is the
//   hit flag and m_tdata the crossing point, zero on a miss or when the
//   segments are parallel.
//   The block has COORD_BITS + 6 register stages: five front-end stages for
//   differences, products, cross products, magnitudes and numerators; one
//   divider stage per quotient bit; one output stage, which registers the
//   crossing point and hit flag for m_tdata and m_tuser. An item can be
//   accepted every cycle while m_tready is high.
//   Each stage holds its item only while the stage after it is full and
//   stalled, so a stall at m_tready fills the empty stages first and s_tready
//   falls only once every stage holds an item. Nothing is lost or repeated.
//   Reset clears all valid bits; the block takes an item in the next cycle.
// ----------------------------------------------------------------------------
module segment_segment_intersect #(
  parameter int COORD_BITS = ssi_pkg::COORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0 up: first_start_x, first_start_y, first_end_x,
  // first_end_y, second_start_x, second_start_y, second_end_x, second_end_y.
  input  logic [8*COORD_BITS-1:0]              s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // Fields from bit 0 up: cross_x, cross_y, zero padding.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]    m_tdata,
  // Fields from bit 0 up: hit.
  output logic                                 m_tuser
);

  localparam int FS     = ssi_pkg::FRONT_STAGES;
  localparam int STAGES = FS + COORD_BITS + 1;
  localparam int OUT_DW = ((2 * COORD_BITS + 7) / 8) * 8;

  logic [STAGES-1:0] valid;
  logic [STAGES:0]   en;

  // A stage may load when it is empty or when its item moves on.
  assign en[STAGES] = m_tready;
  for (genvar k = 0; k < STAGES; k++) begin : g_ctl
    assign en[k] = !valid[k] || en[k+1];
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en[k]) begin
        if (k == 0) begin
          valid[k] <= s_tvalid;
        end else begin
          valid[k] <= valid[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[STAGES-1];

  logic                          hit_f, negx_f, negy_f;
  logic signed [COORD_BITS-1:0]  basex_f, basey_f;
  logic [3*COORD_BITS+1:0]       numx_f, numy_f;
  logic [2*COORD_BITS+1:0]       den_f;

  ssi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk    (clk),
    .en     (en[FS-1:0]),
    .a1x    (s_tdata[0*COORD_BITS +: COORD_BITS]),
    .a1y    (s_tdata[1*COORD_BITS +: COORD_BITS]),
    .a2x    (s_tdata[2*COORD_BITS +: COORD_BITS]),
    .a2y    (s_tdata[3*COORD_BITS +: COORD_BITS]),
    .b1x    (s_tdata[4*COORD_BITS +: COORD_BITS]),
    .b1y    (s_tdata[5*COORD_BITS +: COORD_BITS]),
    .b2x    (s_tdata[6*COORD_BITS +: COORD_BITS]),
    .b2y    (s_tdata[7*COORD_BITS +: COORD_BITS]),
    .hit    (hit_f),
    .neg_x  (negx_f),
    .neg_y  (negy_f),
    .base_x (basex_f),
    .base_y (basey_f),
    .num_x  (numx_f),
    .num_y  (numy_f),
    .den    (den_f)
  );

  logic [COORD_BITS-1:0] quot_x, quot_y;
  logic [COORD_BITS+1:0] side_x;
  logic [COORD_BITS:0]   side_y;

  ssi_div #(.COORD_BITS(COORD_BITS), .SIDE_W(COORD_BITS + 2)) u_div_x (
    .clk      (clk),
    .en       (en[FS +: COORD_BITS]),
    .num      (numx_f),
    .den      (den_f),
    .side_in  ({hit_f, negx_f, basex_f}),
    .quot     (quot_x),
    .side_out (side_x)
  );

  ssi_div #(.COORD_BITS(COORD_BITS), .SIDE_W(COORD_BITS + 1)) u_div_y (
    .clk      (clk),
    .en       (en[FS +: COORD_BITS]),
    .num      (numy_f),
    .den      (den_f),
    .side_in  ({negy_f, basey_f}),
    .quot     (quot_y),
    .side_out (side_y)
  );

  // Output stage: signed offset added to the start point, cleared on a miss.
  logic                       hit_d;
  logic signed [COORD_BITS:0] offx, offy, sumx, sumy;
  logic [COORD_BITS-1:0]      cross_x, cross_y;
  logic                       hit;

  assign hit_d = side_x[COORD_BITS+1];
  assign offx  = side_x[COORD_BITS] ? -$signed({1'b0, quot_x}) : $signed({1'b0, quot_x});
  assign offy  = side_y[COORD_BITS] ? -$signed({1'b0, quot_y}) : $signed({1'b0, quot_y});
  assign sumx  = $signed({side_x[COORD_BITS-1], side_x[COORD_BITS-1:0]}) + offx;
  assign sumy  = $signed({side_y[COORD_BITS-1], side_y[COORD_BITS-1:0]}) + offy;

  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      hit     <= hit_d;
      cross_x <= hit_d ? sumx[COORD_BITS-1:0] : '0;
      cross_y <= hit_d ? sumy[COORD_BITS-1:0] : '0;
    end
  end

  assign m_tdata = OUT_DW'({cross_y, cross_x});
  assign m_tuser = hit;

endmodule

@@ bench/segment_segment_intersect_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_segment_intersect_tb: self-checking bench for the segment crossing
// A queue of segment pairs feeds a stream driver. Every accepted pair is run
// through an exact integer model of the crossing test, and the monitor checks
// each result item against the oldest predicted crossing. The run covers
// directed corner cases, then random pairs under three idling regimes.
// ----------------------------------------------------------------------------
module segment_segment_intersect_tb;

  localparam int CW = ssi_pkg::COORD_BITS;
  localparam int OUT_W = ((2*CW+7)/8)*8;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT_RESULT = 40;

  // Input item layout, first_start_x in the lowest bits.
  typedef struct packed {
    logic signed [CW-1:0] second_end_y;
    logic signed [CW-1:0] second_end_x;
    logic signed [CW-1:0] second_start_y;
    logic signed [CW-1:0] second_start_x;
    logic signed [CW-1:0] first_end_y;
    logic signed [CW-1:0] first_end_x;
    logic signed [CW-1:0] first_start_y;
    logic signed [CW-1:0] first_start_x;
  } seg_pair_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] cross_y;
    logic [CW-1:0] cross_x;
  } crossing_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [8*CW-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tuser;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  failures = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  in_taken = 1'b0;

  segment_segment_intersect DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // A ratio p/c lies in [0,1] when p is zero, or has the sign of c and no
  // larger magnitude.
  function automatic bit within_unit(input longint p, input longint c);
    if (p == 0) return 1'b1;
    if ((p < 0) != (c < 0)) return 1'b0;
    return ((p < 0) ? -p : p) <= ((c < 0) ? -c : c);
  endfunction

  function automatic crossing_t predict_crossing(input seg_pair_t pr);
    crossing_t res;
    longint ax, ay, dax, day, dbx, dby, ox, oy, va, vb, vc;
    ax  = longint'($signed(pr.first_start_x));
    ay  = longint'($signed(pr.first_start_y));
    dax = longint'($signed(pr.first_end_x)) - ax;
    day = longint'($signed(pr.first_end_y)) - ay;
    dbx = longint'($signed(pr.second_end_x)) - longint'($signed(pr.second_start_x));
    dby = longint'($signed(pr.second_end_y)) - longint'($signed(pr.second_start_y));
    ox  = ax - longint'($signed(pr.second_start_x));
    oy  = ay - longint'($signed(pr.second_start_y));
    va  = dbx * oy - dby * ox;
    vb  = dax * oy - day * ox;
    vc  = dby * dax - dbx * day;
    res = '0;
    if (vc == 0 || !within_unit(va, vc) || !within_unit(vb, vc)) return res;
    // Signed division truncates toward zero, as the point offset requires.
    res.hit     = 1'b1;
    res.cross_x = CW'(ax + (va * dax) / vc);
    res.cross_y = CW'(ay + (va * day) / vc);
    return res;
  endfunction

  task automatic add_pair(input int ax1, input int ay1, input int ax2, input int ay2,
                          input int bx1, input int by1, input int bx2, input int by2);
    seg_pair_t pr;
    pr.first_start_x  = CW'(ax1);
    pr.first_start_y  = CW'(ay1);
    pr.first_end_x    = CW'(ax2);
    pr.first_end_y    = CW'(ay2);
    pr.second_start_x = CW'(bx1);
    pr.second_start_y = CW'(by1);
    pr.second_end_x   = CW'(bx2);
    pr.second_end_y   = CW'(by2);
    pending_pairs.push_back(pr);
  endtask

  function automatic int near(input int c, input int span);
    return c + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly pairs that cross or touch, with some noise, parallels and points.
  task automatic add_random_pair();
    int kind, span, px, py, ux, uy, vx, vy, k, m;
    kind = $urandom_range(0, 9);
    span = 1 << $urandom_range(2, 12);
    px = near(0, 16000);
    py = near(0, 16000);
    ux = near(0, span);
    uy = near(0, span);
    vx = near(0, span);
    vy = near(0, span);
    case (kind)
      0, 1: begin
        pending_pairs.push_back(seg_pair_t'({$urandom, $urandom, $urandom, $urandom}));
      end
      2, 3, 4: begin
        add_pair(px + ux, py + uy, near(px, span), near(py, span),
                 px + vx, py + vy, near(px, span), near(py, span));
      end
      5, 6: begin
        add_pair(px - ux, py - uy, px + ux, py + uy, px - vx, py - vy, px + vx, py + vy);
      end
      7: begin
        if ($urandom_range(0, 1))
          add_pair(px + ux, py + uy, px, py, px, py, px + vx, py + vy);
        else
          add_pair(px, py, px + ux, py + uy, px + vx, py + vy, px, py);
      end
      8: begin
        k = int'($urandom_range(0, 4)) - 2;
        m = int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1))
          add_pair(px, py, px + ux, py + uy,
                   px + m * ux, py + m * uy, px + m * ux + k * ux, py + m * uy + k * uy);
        else
          add_pair(px, py, px + ux, py + uy,
                   px + vx, py + vy, px + vx + k * ux, py + vy + k * uy);
      end
      default: begin
        if ($urandom_range(0, 1))
          add_pair(px, py, px, py, px - vx, py - vy, px + vx, py + vy);
        else
          add_pair(px - ux, py - uy, px + ux, py + uy, px + vx, py + vy, px + vx, py + vy);
      end
    endcase
  endtask

  // Driver: a new item goes out once the current one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (pending_pairs.size() > 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
        s_tdata  <= pending_pairs.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off so the pipeline backs up.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (results_seen == HOLD_AT_RESULT && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= int'($urandom_range(0, 99)) >= recv_idle_pct;
    end
  end

  // Monitor: predicts at input acceptance and checks at output acceptance.
  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) expected_crossings.push_back(predict_crossing(s_tdata));
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_crossings.size() == 0) begin
          $display("%0t: unexpected result item: hit %0b x %0d y %0d", $time, m_tuser,
                   $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]));
          failures++;
        end else begin
          want = expected_crossings.pop_front();
          if (m_tuser !== want.hit) begin
            $display("%0t: hit mismatch: expected %0b, got %0b", $time, want.hit, m_tuser);
            failures++;
          end
          if (m_tdata[CW-1:0] !== want.cross_x) begin
            $display("%0t: cross_x mismatch: expected %0d, got %0d", $time,
                     $signed(want.cross_x), $signed(m_tdata[CW-1:0]));
            failures++;
          end
          if (m_tdata[2*CW-1:CW] !== want.cross_y) begin
            $display("%0t: cross_y mismatch: expected %0d, got %0d", $time,
                     $signed(want.cross_y), $signed(m_tdata[2*CW-1:CW]));
            failures++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 36;
    recv_idle_pct = 58;
    add_pair(-16, -16, 16, 16, -16, 16, 16, -16);
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    add_pair(32767, 0, -32768, 0, 0, 32767, 0, -32768);
    add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_pair(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
    // Touching: an end point on the other segment, and shared end points.
    add_pair(0, 0, 100, 0, 100, -50, 100, 50);
    add_pair(0, 0, 64, 64, 64, 64, 128, 0);
    add_pair(0, 0, 64, 64, 128, 0, 0, 0);
    // Parallel, collinear and degenerate segments.
    add_pair(0, 0, 100, 0, 0, 10, 100, 10);
    add_pair(0, 0, 100, 0, 50, 0, 150, 0);
    add_pair(5, 5, 5, 5, 0, 0, 10, 10);
    add_pair(0, 0, 10, 10, 5, 5, 5, 5);
    // Near misses on either parameter.
    add_pair(0, 0, 100, 0, 101, -50, 101, 50);
    add_pair(0, 0, 100, 0, 50, 1, 50, 100);
    add_pair(0, 0, 100, 0, 50, -100, 50, -1);
    // Quotients that truncate, in all sign combinations.
    add_pair(0, 0, -7, -3, -3, 1, -2, -5);
    add_pair(3, -1, -10, 7, -5, -6, 2, 9);
    add_pair(-1, -1, 6, 4, 4, -3, -2, 5);
    repeat (230) add_random_pair();
    while (pending_pairs.size() > 0) @(posedge clk);

    send_idle_pct = 58;
    recv_idle_pct = 36;
    repeat (230) add_random_pair();
    while (pending_pairs.size() > 0) @(posedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (240) add_random_pair();
    while (pending_pairs.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_crossings.size() > 0) @(posedge clk);
    repeat (CW + 12) @(posedge clk);

    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ssi_pkg.sv
rtl/ssi_front.sv
rtl/ssi_div.sv
rtl/segment_segment_intersect.sv
bench/segment_segment_intersect_tb.sv
